### hdl/brr_pkg.sv
// shared types and constants for the brr adpcm sample decoder
`default_nettype none
package brr_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam int unsigned SHIFT_W    = 4;
   localparam int unsigned FILTER_W   = 2;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned NIBBLE_W   = 4;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned SUM_W      = 21;

   localparam logic [SHIFT_W-1:0]         SHIFT_LIMIT   = 4'd12;
   localparam logic signed [SAMPLE_W-1:0] LARGE_NEG     = -16'sd2048;
   localparam logic signed [SUM_W-1:0]    SAMPLE_MAX    = 21'sd32767;
   localparam logic signed [SUM_W-1:0]    SAMPLE_MIN    = -21'sd32768;
   localparam logic [SAMPLE_W-1:0]        SAMPLE_MASK   = 16'hFFFE;

   typedef enum logic [FILTER_W-1:0] {
      FILTER_DIRECT = 2'd0,
      FILTER_ONE    = 2'd1,
      FILTER_TWO    = 2'd2,
      FILTER_THREE  = 2'd3
   } filter_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] residual;
      filter_type                 filter;
      logic                       last;
   } entry_type;

endpackage
`default_nettype wire

### hdl/brr_adpcm_sample_decoder.sv
// top level of the brr adpcm sample decoder
// Each request transfer carries one BRR data byte with its block's shift and
// filter fields and yields two response transfers: the high-nibble sample
// (last_of_pair 0) then the low-nibble sample (last_of_pair 1). The front end
// issues one scaled nibble per cycle into a short queue unless it is full, and
// takes the next byte as the second one is pushed. The back end runs the
// predictor, saturation and sample history update once per cycle unless the
// response side stalls, since each sample feeds the next one's prediction.
// The response side may stall at any time; the queue keeps the front end
// taking bytes until it fills. Reset clears the sample history to zero.
`default_nettype none
module brr_adpcm_sample_decoder #(
   parameter int unsigned QUEUE_DEPTH = brr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [brr_pkg::SHIFT_W-1:0]         req_shift_amount,
   input  wire logic [brr_pkg::FILTER_W-1:0]        req_filter_mode,
   input  wire logic [brr_pkg::BYTE_W-1:0]          req_data_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [brr_pkg::SAMPLE_W-1:0]      rsp_pcm_sample,
   output logic                                     rsp_last_of_pair
);

   logic               q_full, q_empty, q_push, q_pop;
   brr_pkg::entry_type q_push_entry, q_pop_entry;

   brr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_shift_amount (req_shift_amount),
      .req_filter_mode  (req_filter_mode),
      .req_data_byte    (req_data_byte),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_push_entry)
   );

   brr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry),
      .empty      (q_empty)
   );

   brr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_entry          (q_pop_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pcm_sample   (rsp_pcm_sample),
      .rsp_last_of_pair (rsp_last_of_pair)
   );

endmodule
`default_nettype wire

### hdl/brr_front.sv
// front end: takes one byte transfer and issues its two scaled nibbles
`default_nettype none
module brr_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [brr_pkg::SHIFT_W-1:0]       req_shift_amount,
   input  wire logic [brr_pkg::FILTER_W-1:0]      req_filter_mode,
   input  wire logic [brr_pkg::BYTE_W-1:0]        req_data_byte,
   input  wire logic                              q_full,
   output logic                                   q_push,
   output brr_pkg::entry_type                     q_entry
);

   logic                           item_valid_ff, item_valid_in;
   logic                           phase_ff, phase_in;
   logic [brr_pkg::BYTE_W-1:0]     byte_ff, byte_in;
   logic [brr_pkg::SHIFT_W-1:0]    shift_ff, shift_in;
   brr_pkg::filter_type            filter_ff, filter_in;

   logic                           accept;
   logic                           finish;
   logic [brr_pkg::NIBBLE_W-1:0]   nibble;
   logic [brr_pkg::SAMPLE_W:0]     wide;
   logic signed [brr_pkg::SAMPLE_W-1:0] residual;

   assign q_push    = item_valid_ff && !q_full;
   assign finish    = q_push && phase_ff;
   assign req_stall = item_valid_ff && !finish;
   assign accept    = req_valid && !req_stall;

   assign nibble = phase_ff ? byte_ff[brr_pkg::NIBBLE_W-1:0]
                            : byte_ff[brr_pkg::BYTE_W-1:brr_pkg::NIBBLE_W];

   always_comb begin
      wide = {{(brr_pkg::SAMPLE_W + 1 - brr_pkg::NIBBLE_W){nibble[brr_pkg::NIBBLE_W-1]}},
              nibble} << shift_ff;
      if (shift_ff > brr_pkg::SHIFT_LIMIT) begin
         residual = nibble[brr_pkg::NIBBLE_W-1] ? brr_pkg::LARGE_NEG : '0;
      end else begin
         // floor halving of the shifted nibble
         residual = signed'(wide[brr_pkg::SAMPLE_W:1]);
      end
   end

   always_comb begin
      q_entry.residual = residual;
      q_entry.filter   = filter_ff;
      q_entry.last     = phase_ff;
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      phase_in      = phase_ff;
      byte_in       = byte_ff;
      shift_in      = shift_ff;
      filter_in     = filter_ff;
      if (accept) begin
         item_valid_in = 1'b1;
         phase_in      = 1'b0;
         byte_in       = req_data_byte;
         shift_in      = req_shift_amount;
         filter_in     = brr_pkg::filter_type'(req_filter_mode);
      end else if (finish) begin
         item_valid_in = 1'b0;
         phase_in      = 1'b0;
      end else if (q_push) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
      end
      byte_ff   <= byte_in;
      shift_ff  <= shift_in;
      filter_ff <= filter_in;
   end

endmodule
`default_nettype wire

### hdl/brr_queue.sv
// short queue of nibble entries between front and back end
`default_nettype none
module brr_queue #(
   parameter int unsigned DEPTH = brr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire brr_pkg::entry_type push_entry,
   output logic                    full,
   input  wire logic               pop,
   output brr_pkg::entry_type      pop_entry,
   output logic                    empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   brr_pkg::entry_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

### hdl/brr_back.sv
// back end: predictor, saturation, sample history and output register
`default_nettype none
module brr_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                q_empty,
   input  wire brr_pkg::entry_type                  q_entry,
   output logic                                     q_pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [brr_pkg::SAMPLE_W-1:0]      rsp_pcm_sample,
   output logic                                     rsp_last_of_pair
);

   localparam int unsigned SW = brr_pkg::SUM_W;

   logic                                 out_valid_ff, out_valid_in;
   logic signed [brr_pkg::SAMPLE_W-1:0]  sample_ff;
   logic                                 last_ff;
   logic signed [brr_pkg::SAMPLE_W-1:0]  hist1_ff, hist2_ff;

   logic signed [SW-1:0] p1, p2, r, pred, sum;
   logic signed [brr_pkg::SAMPLE_W-1:0]  clamped, sample;

   assign q_pop = !q_empty && (!out_valid_ff || !rsp_stall);

   always_comb begin
      p1 = SW'(hist1_ff);
      p2 = SW'(hist2_ff);
      r  = SW'(q_entry.residual);
      case (q_entry.filter)
         brr_pkg::FILTER_DIRECT: pred = '0;
         brr_pkg::FILTER_ONE:    pred = p1 + ((-p1) >>> 4);
         brr_pkg::FILTER_TWO:    pred = (p1 <<< 1) + ((-(p1 * 21'sd3)) >>> 5)
                                        - p2 + (p2 >>> 4);
         brr_pkg::FILTER_THREE:  pred = (p1 <<< 1) + ((-(p1 * 21'sd13)) >>> 6)
                                        - p2 + ((p2 * 21'sd3) >>> 4);
         default:                pred = '0;
      endcase
      sum = r + pred;
      if (sum > brr_pkg::SAMPLE_MAX) begin
         clamped = brr_pkg::SAMPLE_MAX[brr_pkg::SAMPLE_W-1:0];
      end else if (sum < brr_pkg::SAMPLE_MIN) begin
         clamped = brr_pkg::SAMPLE_MIN[brr_pkg::SAMPLE_W-1:0];
      end else begin
         clamped = sum[brr_pkg::SAMPLE_W-1:0];
      end
      sample = clamped & brr_pkg::SAMPLE_MASK;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         hist1_ff     <= '0;
         hist2_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (q_pop) begin
            hist1_ff <= sample;
            hist2_ff <= hist1_ff;
         end
      end
      if (q_pop) begin
         sample_ff <= sample;
         last_ff   <= q_entry.last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pcm_sample   = sample_ff;
   assign rsp_last_of_pair = last_ff;

endmodule
`default_nettype wire

### hdl/brr_checker.sv
// port checker for the brr adpcm sample decoder and its bind
`default_nettype none
module brr_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [brr_pkg::SAMPLE_W-1:0] rsp_pcm_sample,
   input wire logic                                rsp_last_of_pair
);

   logic expect_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_last_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         expect_last_ff <= !expect_last_ff;
      end
   end

   // samples of a byte come out as a high then low nibble pair
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_pair == expect_last_ff))
      else $error("sample pair order broken");

   a_low_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pcm_sample[0] == 1'b0))
      else $error("sample low bit set");

   // a taken byte transfer is followed by req_stall
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("byte taken on consecutive cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_pcm_sample) && $stable(rsp_last_of_pair)))
      else $error("stalled response changed");

endmodule

bind brr_adpcm_sample_decoder brr_checker u_brr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pcm_sample   (rsp_pcm_sample),
   .rsp_last_of_pair (rsp_last_of_pair)
);
`default_nettype wire
